// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and helpers of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned RND_W       = $clog2(ROUNDS);
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);

  localparam logic [RND_W-1:0] RND_LAST      = RND_W'(ROUNDS - 1);
  localparam logic [POS_W-1:0] LEN_POS       = POS_W'(56);
  localparam logic [7:0]       PAD_MARK_BYTE = 8'h80;
  localparam logic [63:0]      BYTE_BITS     = 64'd8;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;
  typedef word_t [15:0] window_t;

  // taps of the message schedule window, oldest word first
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w9;
    word_t w14;
  } sched_taps_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_phase_t;

  localparam hash_t H_INIT = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t rotr(input word_t x, input int unsigned r);
    return (x >> r) | (x << (32 - r));
  endfunction

endpackage

// ===== rtl/sha_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_in_if
// Message byte channel: valid/ready handshake with byte payload.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_valid, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last_byte,
                output ready);
endinterface

// ===== rtl/sha_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_out_if
// Digest word channel: valid/ready handshake with one digest word per transaction.
// ----------------------------------------------------------------------------
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== rtl/sha_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_round
// Shared round unit: one compression round plus the next schedule word.
// ----------------------------------------------------------------------------
module sha_round (
  input  sha_pkg::hash_t             work_i,
  input  sha_pkg::sched_taps_t       taps_i,
  input  logic [sha_pkg::RND_W-1:0]  round_i,
  output sha_pkg::hash_t             work_o,
  output sha_pkg::word_t             sched_o
);
  import sha_pkg::*;

  word_t big_s0, big_s1, ch, maj, t1, t2, sm_s0, sm_s1;

  always_comb begin
    big_s1 = rotr(work_i[4], 6) ^ rotr(work_i[4], 11) ^ rotr(work_i[4], 25);
    ch     = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    t1     = work_i[7] + big_s1 + ch + ROUND_K[round_i] + taps_i.w0;
    big_s0 = rotr(work_i[0], 2) ^ rotr(work_i[0], 13) ^ rotr(work_i[0], 22);
    maj    = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    t2     = big_s0 + maj;

    work_o[0] = t1 + t2;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];

    // schedule word sixteen ahead of the current round
    sm_s0   = rotr(taps_i.w1, 7) ^ rotr(taps_i.w1, 18) ^ (taps_i.w1 >> 3);
    sm_s1   = rotr(taps_i.w14, 17) ^ rotr(taps_i.w14, 19) ^ (taps_i.w14 >> 10);
    sched_o = taps_i.w0 + sm_s0 + taps_i.w9 + sm_s1;
  end

endmodule

// ===== rtl/sha256_message_hasher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// SHA-256 over a byte stream, with padding and digest word output.
// ----------------------------------------------------------------------------
// A message arrives one byte per transaction on in_if and its SHA-256 digest
// leaves as eight transactions on out_if, word 0 first, last_word set on word 7.
// The transaction that fills a 64-byte block is followed by the 64 rounds of
// the shared round unit and one hash update, during which in_if.ready is low. A
// transaction with last_byte set starts padding: the 0x80 mark, zero bytes
// and the 8-byte length go through the block buffer at one byte per cycle,
// with one or two compressions in between, then the digest words are offered
// one per cycle as out_if.ready allows. The initial hash values and a zero
// length are restored after word 7 leaves, so the next message follows directly.
// A transaction with neither byte_valid nor last_byte does nothing.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top (
  input logic      clk,
  input logic      rst_n,
  sha_in_if.sink   in_if,
  sha_out_if.source out_if
);
  import sha_pkg::*;

  // control state
  state_t           state_r, state_nxt;
  pad_phase_t       phase_r, phase_nxt;
  logic             pad_on_r, pad_on_nxt;     // message closed, padding in progress
  logic             pad_done_r, pad_done_nxt; // last length byte written
  logic [2:0]       len_cnt_r, len_cnt_nxt;
  logic [2:0]       widx_r, widx_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [63:0]      bitlen_r, bitlen_nxt;     // doubles as length byte shifter
  hash_t            hash_r, hash_nxt;

  // datapath
  window_t          win_r, win_nxt;           // block buffer and schedule window
  hash_t            work_r, work_nxt;

  logic             byte_we;
  logic [7:0]       byte_val;
  logic [POS_W-1:0] pos_inc;
  sched_taps_t      taps;
  hash_t            round_work;
  word_t            round_sched;

  assign taps.w0  = win_r[0];
  assign taps.w1  = win_r[1];
  assign taps.w9  = win_r[9];
  assign taps.w14 = win_r[14];

  sha_round u_round (
    .work_i  (work_r),
    .taps_i  (taps),
    .round_i (rnd_r),
    .work_o  (round_work),
    .sched_o (round_sched)
  );

  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = (state_r == ST_EMIT);
  assign out_if.digest_word = hash_r[0];
  assign out_if.word_index  = widx_r;
  assign out_if.last_word   = (widx_r == 3'd7);

  assign pos_inc = pos_r + POS_W'(1);

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    pad_on_nxt   = pad_on_r;
    pad_done_nxt = pad_done_r;
    len_cnt_nxt  = len_cnt_r;
    widx_nxt     = widx_r;
    pos_nxt      = pos_r;
    rnd_nxt      = rnd_r;
    bitlen_nxt   = bitlen_r;
    hash_nxt     = hash_r;
    win_nxt      = win_r;
    work_nxt     = work_r;
    byte_we      = 1'b0;
    byte_val     = 8'h00;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          if (in_if.byte_valid) begin
            byte_we    = 1'b1;
            byte_val   = in_if.data_byte;
            bitlen_nxt = bitlen_r + BYTE_BITS;
          end
          if (in_if.last_byte) begin
            pad_on_nxt   = 1'b1;
            pad_done_nxt = 1'b0;
            phase_nxt    = PH_MARK;
            len_cnt_nxt  = 3'd0;
            state_nxt    = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        byte_we = 1'b1;
        case (phase_r)
          PH_MARK: begin
            byte_val  = PAD_MARK_BYTE;
            phase_nxt = (pos_inc == LEN_POS) ? PH_LEN : PH_ZERO;
          end
          PH_ZERO: begin
            byte_val  = 8'h00;
            phase_nxt = (pos_inc == LEN_POS) ? PH_LEN : PH_ZERO;
          end
          PH_LEN: begin
            // length goes out big-endian, the shifter ends at zero
            byte_val    = bitlen_r[63:56];
            bitlen_nxt  = {bitlen_r[55:0], 8'h00};
            len_cnt_nxt = len_cnt_r + 3'd1;
            if (len_cnt_r == 3'd7) begin
              pad_done_nxt = 1'b1;
            end
          end
          default: begin
            byte_we = 1'b0;
          end
        endcase
      end

      ST_ROUND: begin
        work_nxt = round_work;
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[15] = round_sched;
        rnd_nxt     = rnd_r + RND_W'(1);
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + work_r[i];
        end
        if (pad_done_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_on_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_if.ready) begin
          widx_nxt = widx_r + 3'd1;
          hash_nxt = {hash_r[0], hash_r[7:1]};
          if (widx_r == 3'd7) begin
            hash_nxt     = H_INIT;
            pad_on_nxt   = 1'b0;
            pad_done_nxt = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte packing: whole block shifts left by one byte, big-endian words
    if (byte_we) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], byte_val};
      pos_nxt     = pos_inc;
      // block full: compress it before anything else
      if (pos_inc == '0) begin
        state_nxt = ST_ROUND;
        work_nxt  = hash_r;
        rnd_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_MARK;
      pad_on_r   <= 1'b0;
      pad_done_r <= 1'b0;
      len_cnt_r  <= 3'd0;
      widx_r     <= 3'd0;
      pos_r      <= '0;
      rnd_r      <= '0;
      bitlen_r   <= '0;
      hash_r     <= H_INIT;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      pad_on_r   <= pad_on_nxt;
      pad_done_r <= pad_done_nxt;
      len_cnt_r  <= len_cnt_nxt;
      widx_r     <= widx_nxt;
      pos_r      <= pos_nxt;
      rnd_r      <= rnd_nxt;
      bitlen_r   <= bitlen_nxt;
      hash_r     <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    work_r <= work_nxt;
  end

endmodule
